// File: src/iirdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf_pkg: shared constants and types of the direct-form-I IIR filter
// Widths, register map, sequencer states and the MAC control bundle.
// ----------------------------------------------------------------------------
package iirdf_pkg;

	// Filter order; taps above it are never used.
	localparam int ORDER     = 3;

	localparam int SAMPLE_W  = 16;  // input and output samples
	localparam int COEF_W    = 32;  // Q8.24 coefficients
	localparam int HIST_W    = 24;  // Q16.8 output history
	localparam int FRAC_Y    = 8;   // fraction bits of the output history
	localparam int COEF_FRAC = 24;  // fraction bits of a coefficient
	localparam int OPA_W     = HIST_W;
	localparam int PROD_W    = OPA_W + COEF_W;
	localparam int ACC_W     = 60;
	localparam int HFULL_W   = ACC_W - COEF_FRAC;

	localparam int TAP_W     = $clog2(ORDER + 1);
	localparam int HIDX_W    = (ORDER > 1) ? $clog2(ORDER) : 1;

	// Register map: feedforward b0..b3 at 0..3, feedback a1..a3 at 4..6.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_FF_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FB_BASE = 3'd4;

	localparam logic signed [COEF_W-1:0] FF0_RESET = 32'sd16777216;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_RND,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic clr;
		logic en;
		logic neg;
	} mac_ctl_t;

endpackage
`default_nettype wire

// File: src/iirdf_coef.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf_coef: coefficient register file
// Holds b0..bORDER and a1..aORDER, written through the configuration port and
// read one at a time by the sequencer.
// ----------------------------------------------------------------------------
module iirdf_coef import iirdf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [COEF_W-1:0]        cfg_data,
	input  wire logic [TAP_W-1:0]         tap,
	input  wire logic [HIDX_W-1:0]        hidx,
	input  wire logic                     fb_sel,
	output logic signed [COEF_W-1:0]      coef
);

	logic signed [COEF_W-1:0] ff_q [ORDER+1];
	logic signed [COEF_W-1:0] fb_q [ORDER];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= ORDER; i++) begin
				ff_q[i] <= (i == 0) ? FF0_RESET : '0;
			end
			for (int i = 0; i < ORDER; i++) begin
				fb_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index <= REG_FF_BASE + CFG_IDX_W'(ORDER)) begin
				ff_q[cfg_index[TAP_W-1:0]] <= cfg_data;
			end else if (cfg_index >= REG_FB_BASE &&
			             cfg_index < REG_FB_BASE + CFG_IDX_W'(ORDER)) begin
				fb_q[HIDX_W'(cfg_index - REG_FB_BASE)] <= cfg_data;
			end
		end
	end

	assign coef = fb_sel ? fb_q[hidx] : ff_q[tap];

endmodule
`default_nettype wire

// File: src/iirdf_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf_mac: shared multiply-accumulate unit
// One signed 24x32 multiply into a product register, then add or subtract
// into a 60-bit accumulator on the following cycle.
// ----------------------------------------------------------------------------
module iirdf_mac import iirdf_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire mac_ctl_t                 ctl,
	input  wire logic signed [OPA_W-1:0]  opa,
	input  wire logic signed [COEF_W-1:0] opb,
	output logic signed [ACC_W-1:0]       acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     vld_s1;
	logic                     neg_s1;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  prod_ext;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opa * opb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			neg_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl.en;
			neg_s1 <= ctl.neg;
		end
	end

	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= neg_s1 ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// File: src/iir_direct_form_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iir_direct_form_filter: streaming direct-form-I IIR filter
// y[n] = sum b_k x[n-k] - sum a_k y[n-k], one shared MAC under a sequencer,
// rounded to Q16.8 history and to a saturated 16-bit output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tdata: sample_in, tuser: first_of_record
//  m_axis    out        m_axis_tvalid/tready    tdata: sample_out, tuser: clipped
//  cfg       in         cfg_we                  cfg_index, cfg_data
//
// An item passes through the sequencer one step at a time: the single multiplier
// takes one tap per cycle in ST_MAC, ST_DRAIN empties its product register, and
// ST_RND and ST_FIN round the result; a new item is taken only back in ST_IDLE.
// Reset restores b0 to 1.0, all other coefficients and both histories to zero.
// A result not taken holds the sequencer in its final step; input is not
// accepted until the sequencer is idle again.
// ----------------------------------------------------------------------------
module iir_direct_form_filter import iirdf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample_in
	input  wire logic                   s_axis_tuser,   // [0] first_of_record
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [SAMPLE_W-1:0]         m_axis_tdata,   // [15:0] sample_out
	output logic                        m_axis_tuser,   // [0] clipped
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [COEF_W-1:0]      cfg_data
);

	localparam logic signed [HFULL_W-1:0] H_MAX = HFULL_W'(2**(HIST_W-1) - 1);
	localparam logic signed [HFULL_W-1:0] H_MIN = HFULL_W'(-(2**(HIST_W-1)));
	localparam logic signed [HIST_W-FRAC_Y:0] O_MAX =
		(HIST_W-FRAC_Y+1)'(2**(SAMPLE_W-1) - 1);
	localparam logic signed [HIST_W-FRAC_Y:0] O_MIN =
		(HIST_W-FRAC_Y+1)'(-(2**(SAMPLE_W-1)));

	seq_state_t state_q, state_d;
	logic [TAP_W-1:0]  tap_q, tap_d;
	logic              fb_q, fb_d;
	logic [HIDX_W-1:0] hidx;
	mac_ctl_t          mac_ctl;

	logic signed [SAMPLE_W-1:0] x_q;
	logic signed [SAMPLE_W-1:0] in_hist_q  [ORDER];
	logic signed [HIST_W-1:0]   out_hist_q [ORDER];

	logic signed [OPA_W-1:0]  opa;
	logic signed [COEF_W-1:0] coef;
	logic signed [ACC_W-1:0]  acc;

	logic signed [ACC_W-1:0]   hsum;
	logic signed [HFULL_W-1:0] hfull;
	logic signed [HIST_W-1:0]  h_q;
	logic                      hclip_q;
	logic signed [HIST_W:0]    osum;
	logic signed [HIST_W-FRAC_Y:0] ofull;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic                      oclip;

	logic out_vld_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic out_clip_q;

	logic accept;
	logic adv;

	assign accept = s_axis_tvalid && s_axis_tready;
	assign adv    = (state_q == ST_FIN) && (!out_vld_q || m_axis_tready);
	assign hidx   = (tap_q == '0) ? '0 : HIDX_W'(tap_q - 1'b1);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			fb_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			fb_q    <= fb_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		tap_d         = tap_q;
		fb_d          = fb_q;
		mac_ctl       = '0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					mac_ctl.clr = 1'b1;
					tap_d       = '0;
					fb_d        = 1'b0;
					state_d     = ST_MAC;
				end
			end
			ST_MAC: begin
				mac_ctl.en  = 1'b1;
				mac_ctl.neg = fb_q;
				if (tap_q == TAP_W'(ORDER) && fb_q) begin
					state_d = ST_DRAIN;
				end else if (tap_q == '0 || fb_q) begin
					tap_d = tap_q + 1'b1;
					fb_d  = 1'b0;
				end else begin
					fb_d = 1'b1;
				end
			end
			ST_DRAIN: state_d = ST_RND;
			ST_RND:   state_d = ST_FIN;
			ST_FIN: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Operand selection for the shared MAC
	always_comb begin
		if (fb_q) begin
			opa = out_hist_q[hidx];
		end else if (tap_q == '0) begin
			opa = {x_q, {FRAC_Y{1'b0}}};
		end else begin
			opa = {in_hist_q[hidx], {FRAC_Y{1'b0}}};
		end
	end

	iirdf_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tap       (tap_q),
		.hidx      (hidx),
		.fb_sel    (fb_q),
		.coef      (coef)
	);

	iirdf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.opa    (opa),
		.opb    (coef),
		.acc    (acc)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= s_axis_tdata;
		end
	end

	// Round the Q.32 sum to Q16.8 history with saturation.
	assign hsum  = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
	assign hfull = hsum[ACC_W-1:COEF_FRAC];

	always_ff @(posedge clk) begin
		if (state_q == ST_RND) begin
			if (hfull > H_MAX) begin
				h_q     <= H_MAX[HIST_W-1:0];
				hclip_q <= 1'b1;
			end else if (hfull < H_MIN) begin
				h_q     <= H_MIN[HIST_W-1:0];
				hclip_q <= 1'b1;
			end else begin
				h_q     <= hfull[HIST_W-1:0];
				hclip_q <= 1'b0;
			end
		end
	end

	// Round the history value to an integer sample with saturation.
	assign osum  = {h_q[HIST_W-1], h_q} + (HIST_W+1)'(2**(FRAC_Y-1));
	assign ofull = osum[HIST_W:FRAC_Y];

	always_comb begin
		oclip = 1'b1;
		if (ofull > O_MAX) begin
			o_sat = O_MAX[SAMPLE_W-1:0];
		end else if (ofull < O_MIN) begin
			o_sat = O_MIN[SAMPLE_W-1:0];
		end else begin
			o_sat = ofull[SAMPLE_W-1:0];
			oclip = 1'b0;
		end
	end

	// Histories: cleared at the start of a record, shifted when a result retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER; i++) begin
				in_hist_q[i]  <= '0;
				out_hist_q[i] <= '0;
			end
		end else if (accept && s_axis_tuser) begin
			for (int i = 0; i < ORDER; i++) begin
				in_hist_q[i]  <= '0;
				out_hist_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = ORDER - 1; i > 0; i--) begin
				in_hist_q[i]  <= in_hist_q[i-1];
				out_hist_q[i] <= out_hist_q[i-1];
			end
			in_hist_q[0]  <= x_q;
			out_hist_q[0] <= h_q;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= o_sat;
			out_clip_q <= hclip_q | oclip;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_clip_q;

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input accepted while a sample is still being filtered");

	a_round_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RND |-> $past(state_q) == ST_DRAIN)
		else $error("rounding started before the last product was accumulated");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap_q <= TAP_W'(ORDER))
		else $error("tap counter ran past the filter order");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_FIN)
		else $error("result presented outside the final step");

endmodule
`default_nettype wire
